// ===== rtl/core/cnd_pkg.sv =====
package cnd_pkg;

   // Field widths of the request and result channels.
   localparam int NUM_DENOM = 8;
   localparam int DENOM_W = 3;
   localparam int COUNT_W = 14;
   localparam int AMOUNT_W = 18;
   localparam int VALUE_W = 9;

   // Products and saturation limits.
   localparam int REFILL_PROD_W = COUNT_W + VALUE_W;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int DIV_PROD_W = AMOUNT_W + RECIP_W;
   localparam int QUOT_W = DIV_PROD_W - RECIP_SHIFT;
   localparam int STOCK_MAX = 16383;
   localparam int BAL_MAX = 262143;

   // Default stock of the largest note; each smaller note holds twice the one above.
   localparam int BASE_STOCK_DEF = 100;

   // Note values, largest first.
   localparam logic [VALUE_W-1:0] NOTE_VALUE [NUM_DENOM] = '{
      9'd500, 9'd150, 9'd50, 9'd20, 9'd10, 9'd5, 9'd2, 9'd1
   };

   // Rounded-up reciprocals scaled by 2^RECIP_SHIFT; exact quotients for 18-bit amounts.
   localparam logic [RECIP_W-1:0] NOTE_RECIP [NUM_DENOM] = '{
      29'd536871, 29'd1789570, 29'd5368710, 29'd13421773,
      29'd26843546, 29'd53687092, 29'd134217728, 29'd268435456
   };

   typedef enum logic [2:0] {
      STS_OK = 3'd0,
      STS_OVER = 3'd1,
      STS_CANCEL = 3'd2,
      STS_EMPTY = 3'd3,
      STS_REFILL_BAD = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_DIV,
      S_UPD,
      S_FIN,
      S_REF_APPLY,
      S_SEND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic ref_eval;
      logic ref_apply;
      logic load_status;
      logic div;
      logic upd;
      logic finish;
      logic load_note;
      logic [DENOM_W-1:0] idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_refill;
      logic special;
      logic last;
   } sts_type;

   // Capacity of one note kind, saturated at the stock width.
   function automatic logic [COUNT_W-1:0] capacity(input int base, input logic [DENOM_W-1:0] i);
      int c;
      c = base << i;
      if (c > STOCK_MAX) begin
         c = STOCK_MAX;
      end
      return COUNT_W'(c);
   endfunction

   // Cash held by a fully stocked machine, saturated at the balance width.
   function automatic logic [AMOUNT_W-1:0] reset_balance(input int base);
      longint s;
      s = 0;
      for (int k = 0; k < NUM_DENOM; k++) begin
         s = s + longint'(capacity(base, DENOM_W'(k))) * longint'(NOTE_VALUE[k]);
      end
      if (s > BAL_MAX) begin
         s = BAL_MAX;
      end
      return AMOUNT_W'(s);
   endfunction

endpackage

// ===== rtl/core/cash_note_dispenser_unit.sv =====
// Note dispenser with eight note kinds (500, 150, 50, 20, 10, 5, 2, 1) and a cash balance.
// Request channel: req_valid/req_stall with req_type (0 withdraw, 1 refill), req_amount,
// req_denom_index and req_refill_count. A request is taken when req_valid is high and
// req_stall is low; req_stall stays high until the last result of the previous request
// has been taken. Result channel: rsp_valid/rsp_stall with one result per note kind for
// a withdrawal (rsp_last on the eighth) and a single result for a refill or a status case.
// A status result is loaded in the decide state once the request is taken; a refill is
// checked in the decide state and its result is loaded in the apply state. A withdrawal
// walks the note kinds one at a time through a shared reciprocal multiplier, a divide and
// an update state per kind; its first result is loaded after the last kind, and the rest
// follow one per cycle while the receiver does not stall.
// A stalled result holds its value and the block simply waits.
// Reset fills every note kind to its capacity (BASE_STOCK times two to the kind index,
// capped at 16383) and sets the balance to the value of that stock.
module cash_note_dispenser_unit #(
   parameter int BASE_STOCK = cnd_pkg::BASE_STOCK_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [cnd_pkg::AMOUNT_W-1:0]  req_amount,
   input  logic [cnd_pkg::DENOM_W-1:0]   req_denom_index,
   input  logic [cnd_pkg::COUNT_W-1:0]   req_refill_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cnd_pkg::DENOM_W-1:0]   rsp_note_kind,
   output logic [cnd_pkg::COUNT_W-1:0]   rsp_note_count,
   output logic [2:0]                    rsp_status,
   output logic [cnd_pkg::AMOUNT_W-1:0]  rsp_undispensed,
   output logic [cnd_pkg::AMOUNT_W-1:0]  rsp_balance,
   output logic                          rsp_last
);
   import cnd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer for request decode, the per-kind split and result delivery.
   cnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Stock, balance, arithmetic and the result register.
   cnd_datapath #(
      .BASE_STOCK (BASE_STOCK)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_amount       (req_amount),
      .req_denom_index  (req_denom_index),
      .req_refill_count (req_refill_count),
      .rsp_note_kind    (rsp_note_kind),
      .rsp_note_count   (rsp_note_count),
      .rsp_status       (rsp_status),
      .rsp_undispensed  (rsp_undispensed),
      .rsp_balance      (rsp_balance),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== rtl/core/cnd_ctrl.sv =====
module cnd_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  cnd_pkg::sts_type sts,
   output cnd_pkg::cmd_type cmd
);
   import cnd_pkg::*;

   state_type          state_ff, state_in;
   logic [DENOM_W-1:0] idx_ff, idx_in;
   logic               valid_ff, valid_in;

   localparam logic [DENOM_W-1:0] LAST_IDX = DENOM_W'(NUM_DENOM - 1);

   assign rsp_valid = valid_ff;

   // State, index and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      valid_in = valid_ff;
      req_stall = 1'b1;
      cmd = '0;
      cmd.idx = idx_ff;
      case (state_ff)
         S_IDLE: begin
            // Requests are held off while reset is applied.
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.is_refill) begin
               cmd.ref_eval = 1'b1;
               state_in = S_REF_APPLY;
            end else if (sts.special) begin
               cmd.load_status = 1'b1;
               valid_in = 1'b1;
               state_in = S_SEND;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in = '0;
               state_in = S_FIN;
            end else begin
               idx_in = idx_ff + DENOM_W'(1);
               state_in = S_DIV;
            end
         end
         S_FIN: begin
            // Settle the balance and present the first note result.
            cmd.finish = 1'b1;
            cmd.load_note = 1'b1;
            valid_in = 1'b1;
            state_in = S_SEND;
         end
         S_REF_APPLY: begin
            cmd.ref_apply = 1'b1;
            valid_in = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            // On each taken result, either finish or load the next note result.
            if (!rsp_stall) begin
               if (sts.last) begin
                  valid_in = 1'b0;
                  idx_in = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + DENOM_W'(1);
                  cmd.idx = idx_ff + DENOM_W'(1);
                  cmd.load_note = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/cnd_datapath.sv =====
module cnd_datapath #(
   parameter int BASE_STOCK = cnd_pkg::BASE_STOCK_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cnd_pkg::cmd_type              cmd,
   output cnd_pkg::sts_type              sts,
   input  logic                          req_type,
   input  logic [cnd_pkg::AMOUNT_W-1:0]  req_amount,
   input  logic [cnd_pkg::DENOM_W-1:0]   req_denom_index,
   input  logic [cnd_pkg::COUNT_W-1:0]   req_refill_count,
   output logic [cnd_pkg::DENOM_W-1:0]   rsp_note_kind,
   output logic [cnd_pkg::COUNT_W-1:0]   rsp_note_count,
   output logic [2:0]                    rsp_status,
   output logic [cnd_pkg::AMOUNT_W-1:0]  rsp_undispensed,
   output logic [cnd_pkg::AMOUNT_W-1:0]  rsp_balance,
   output logic                          rsp_last
);
   import cnd_pkg::*;

   localparam logic [DENOM_W-1:0] LAST_IDX = DENOM_W'(NUM_DENOM - 1);

   // Request and working registers.
   logic                     type_ff;
   logic [AMOUNT_W-1:0]      amount_ff;
   logic [DENOM_W-1:0]       denom_ff;
   logic [COUNT_W-1:0]       refill_ff;
   logic [AMOUNT_W-1:0]      rest_ff;
   logic [QUOT_W-1:0]        quot_ff;
   logic [COUNT_W-1:0]       taken_ff [NUM_DENOM];
   logic [REFILL_PROD_W-1:0] ref_prod_ff;
   logic                     ref_ok_ff;

   // Machine state.
   logic [COUNT_W-1:0]       stock_ff [NUM_DENOM];
   logic [AMOUNT_W-1:0]      balance_ff, balance_in;
   logic                     stock_we;
   logic [COUNT_W-1:0]       stock_in;

   // Result register.
   logic [DENOM_W-1:0]       kind_ff;
   logic [COUNT_W-1:0]       count_ff;
   status_type               status_ff;
   logic [AMOUNT_W-1:0]      und_ff;
   logic                     last_ff;

   // Combinational terms.
   logic [DENOM_W-1:0]       rd_idx;
   logic [COUNT_W-1:0]       stock_rd;
   logic [DIV_PROD_W-1:0]    div_prod;
   logic [COUNT_W-1:0]       take;
   logic [REFILL_PROD_W-1:0] take_value;
   logic [AMOUNT_W-1:0]      rest_next;
   logic [AMOUNT_W-1:0]      paid;
   logic [COUNT_W:0]         new_stock;
   logic                     ref_ok;
   logic [REFILL_PROD_W-1:0] ref_prod;
   logic [REFILL_PROD_W:0]   sum_bal;
   logic [AMOUNT_W-1:0]      ref_bal;
   logic                     bal_zero;
   logic                     over;
   logic                     cancel;
   status_type               special_code;

   // One stock read port: the refill kind, or the note kind being worked on.
   assign rd_idx = type_ff ? denom_ff : cmd.idx;
   assign stock_rd = stock_ff[rd_idx];

   // Withdrawal checks, empty machine first.
   assign bal_zero = (balance_ff == '0);
   assign over = (amount_ff > balance_ff);
   assign cancel = (amount_ff == '0);

   always_comb begin
      if (bal_zero) begin
         special_code = STS_EMPTY;
      end else if (over) begin
         special_code = STS_OVER;
      end else begin
         special_code = STS_CANCEL;
      end
   end

   assign sts.is_refill = type_ff;
   assign sts.special = bal_zero | over | cancel;
   assign sts.last = last_ff;

   // Quotient by reciprocal multiplication; registered before the next multiply.
   assign div_prod = DIV_PROD_W'(rest_ff) * DIV_PROD_W'(NOTE_RECIP[cmd.idx]);

   // Notes taken are capped by stock, and their value leaves the remainder.
   assign take = (quot_ff > QUOT_W'(stock_rd)) ? stock_rd : quot_ff[COUNT_W-1:0];
   assign take_value = REFILL_PROD_W'(take) * REFILL_PROD_W'(NOTE_VALUE[cmd.idx]);
   assign rest_next = rest_ff - take_value[AMOUNT_W-1:0];
   assign paid = amount_ff - rest_ff;

   // Refill check and value of the added notes.
   assign new_stock = {1'b0, stock_rd} + {1'b0, refill_ff};
   assign ref_ok = (new_stock <= {1'b0, capacity(BASE_STOCK, denom_ff)});
   assign ref_prod = REFILL_PROD_W'(refill_ff) * REFILL_PROD_W'(NOTE_VALUE[denom_ff]);
   assign sum_bal = (REFILL_PROD_W + 1)'(balance_ff) + (REFILL_PROD_W + 1)'(ref_prod_ff);
   assign ref_bal = (sum_bal > (REFILL_PROD_W + 1)'(BAL_MAX)) ?
                    AMOUNT_W'(BAL_MAX) : sum_bal[AMOUNT_W-1:0];

   // Next balance and stock write.
   always_comb begin
      balance_in = balance_ff;
      stock_we = 1'b0;
      stock_in = stock_rd;
      if (cmd.finish) begin
         balance_in = (paid > balance_ff) ? '0 : balance_ff - paid;
      end
      if (cmd.upd) begin
         stock_we = 1'b1;
         stock_in = stock_rd - take;
      end
      if (cmd.ref_apply && ref_ok_ff) begin
         balance_in = ref_bal;
         stock_we = 1'b1;
         stock_in = new_stock[COUNT_W-1:0];
      end
   end

   // Stock and balance start full.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_DENOM; k++) begin
            stock_ff[k] <= capacity(BASE_STOCK, DENOM_W'(k));
         end
         balance_ff <= reset_balance(BASE_STOCK);
      end else begin
         balance_ff <= balance_in;
         if (stock_we) begin
            stock_ff[rd_idx] <= stock_in;
         end
      end
   end

   // Request capture and the greedy split.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         amount_ff <= req_amount;
         denom_ff <= req_denom_index;
         refill_ff <= req_refill_count;
         rest_ff <= req_amount;
      end
      if (cmd.div) begin
         quot_ff <= div_prod[DIV_PROD_W-1:RECIP_SHIFT];
      end
      if (cmd.upd) begin
         rest_ff <= rest_next;
         taken_ff[cmd.idx] <= take;
      end
      if (cmd.ref_eval) begin
         ref_prod_ff <= ref_prod;
         ref_ok_ff <= ref_ok;
      end
   end

   // Result register loads.
   always_ff @(posedge clock) begin
      if (cmd.load_status) begin
         kind_ff <= '0;
         count_ff <= '0;
         status_ff <= special_code;
         und_ff <= '0;
         last_ff <= 1'b1;
      end
      if (cmd.load_note) begin
         kind_ff <= cmd.idx;
         count_ff <= taken_ff[cmd.idx];
         status_ff <= STS_OK;
         und_ff <= (cmd.idx == LAST_IDX) ? rest_ff : '0;
         last_ff <= (cmd.idx == LAST_IDX);
      end
      if (cmd.ref_apply) begin
         kind_ff <= denom_ff;
         count_ff <= ref_ok_ff ? new_stock[COUNT_W-1:0] : stock_rd;
         status_ff <= ref_ok_ff ? STS_OK : STS_REFILL_BAD;
         und_ff <= '0;
         last_ff <= 1'b1;
      end
   end

   assign rsp_note_kind = kind_ff;
   assign rsp_note_count = count_ff;
   assign rsp_status = 3'(status_ff);
   assign rsp_undispensed = und_ff;
   assign rsp_balance = balance_ff;
   assign rsp_last = last_ff;

endmodule

// ===== test/cash_note_dispenser_checker.sv =====
// Watches both channels of the note dispenser, keeps its own copy of the stock and the
// balance, and checks every result against the expected one in request order.
module cash_note_dispenser_checker #(
   parameter int BASE_STOCK = cnd_pkg::BASE_STOCK_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         req_type,
   input  logic [cnd_pkg::AMOUNT_W-1:0] req_amount,
   input  logic [cnd_pkg::DENOM_W-1:0]  req_denom_index,
   input  logic [cnd_pkg::COUNT_W-1:0]  req_refill_count,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [cnd_pkg::DENOM_W-1:0]  rsp_note_kind,
   input  logic [cnd_pkg::COUNT_W-1:0]  rsp_note_count,
   input  logic [2:0]                   rsp_status,
   input  logic [cnd_pkg::AMOUNT_W-1:0] rsp_undispensed,
   input  logic [cnd_pkg::AMOUNT_W-1:0] rsp_balance,
   input  logic                         rsp_last,
   output int                           fail_count,
   output int                           pending_count,
   output int                           checked_count,
   output int                           shortfall_count,
   output int                           refused_count
);
   import cnd_pkg::*;

   localparam int unsigned NOTE_WORTH [NUM_DENOM] = '{500, 150, 50, 20, 10, 5, 2, 1};

   typedef struct packed {
      logic [DENOM_W-1:0]  kind;
      logic [COUNT_W-1:0]  count;
      status_type          status;
      logic [AMOUNT_W-1:0] undisp;
      logic [AMOUNT_W-1:0] bal;
      logic                last;
   } note_result_type;

   int unsigned     stock_level [NUM_DENOM];
   int unsigned     cash_on_hand;
   note_result_type expected_notes [$];
   int              mismatches;
   int              results_seen;
   int              shortfalls;
   int              refusals;

   // Capacity of one note kind, saturated at the stock width.
   function automatic int unsigned note_capacity(input int unsigned idx);
      int unsigned cap;
      cap = BASE_STOCK << idx;
      if (cap > STOCK_MAX) begin
         cap = STOCK_MAX;
      end
      return cap;
   endfunction

   function automatic note_result_type make_result(input int unsigned kind,
                                                   input int unsigned count,
                                                   input status_type st,
                                                   input int unsigned undisp,
                                                   input int unsigned bal, input logic last);
      note_result_type r;
      r.kind = DENOM_W'(kind);
      r.count = COUNT_W'(count);
      r.status = st;
      r.undisp = AMOUNT_W'(undisp);
      r.bal = AMOUNT_W'(bal);
      r.last = last;
      return r;
   endfunction

   // Fill every note kind to capacity and set the balance to the value held.
   task automatic restock_all();
      longint unsigned total;
      total = 0;
      for (int i = 0; i < NUM_DENOM; i++) begin
         stock_level[i] = note_capacity(i);
         total += longint'(stock_level[i]) * NOTE_WORTH[i];
      end
      cash_on_hand = (total > BAL_MAX) ? BAL_MAX : int'(total);
   endtask

   // Apply one request to the local state and queue the results it must produce.
   task automatic predict_request(input logic is_refill, input int unsigned amount,
                                  input int unsigned idx, input int unsigned count);
      int unsigned     rest;
      int unsigned     quota;
      int unsigned     paid;
      int unsigned     new_level;
      int unsigned     taken [NUM_DENOM];
      longint unsigned raised;
      if (is_refill) begin
         new_level = stock_level[idx] + count;
         if (new_level > note_capacity(idx)) begin
            expected_notes.push_back(make_result(idx, stock_level[idx], STS_REFILL_BAD, 0,
                                                 cash_on_hand, 1'b1));
         end else begin
            stock_level[idx] = new_level;
            raised = longint'(cash_on_hand) + longint'(count) * NOTE_WORTH[idx];
            cash_on_hand = (raised > BAL_MAX) ? BAL_MAX : int'(raised);
            expected_notes.push_back(make_result(idx, new_level, STS_OK, 0, cash_on_hand, 1'b1));
         end
      end else if (cash_on_hand == 0) begin
         expected_notes.push_back(make_result(0, 0, STS_EMPTY, 0, cash_on_hand, 1'b1));
      end else if (amount > cash_on_hand) begin
         expected_notes.push_back(make_result(0, 0, STS_OVER, 0, cash_on_hand, 1'b1));
      end else if (amount == 0) begin
         expected_notes.push_back(make_result(0, 0, STS_CANCEL, 0, cash_on_hand, 1'b1));
      end else begin
         // Greedy split from the largest note down, each count capped by its stock.
         rest = amount;
         for (int i = 0; i < NUM_DENOM; i++) begin
            quota = rest / NOTE_WORTH[i];
            if (quota > stock_level[i]) begin
               quota = stock_level[i];
            end
            stock_level[i] -= quota;
            rest -= quota * NOTE_WORTH[i];
            taken[i] = quota;
         end
         paid = amount - rest;
         cash_on_hand = (paid > cash_on_hand) ? 0 : cash_on_hand - paid;
         for (int i = 0; i < NUM_DENOM; i++) begin
            expected_notes.push_back(make_result(i, taken[i], STS_OK,
                                                 (i == NUM_DENOM - 1) ? rest : 0, cash_on_hand,
                                                 i == NUM_DENOM - 1));
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("[%0t] mismatch on result %0d: %s is %0d, expected %0d", $time, results_seen,
               what, got, want);
   endtask

   // Compare the result on the channel with the oldest expected one.
   task automatic check_result();
      note_result_type want;
      results_seen++;
      if (expected_notes.size() == 0) begin
         report_mismatch("result with no request pending, note_kind", rsp_note_kind, '0);
      end else begin
         want = expected_notes.pop_front();
         if (rsp_note_kind !== want.kind) begin
            report_mismatch("note_kind", rsp_note_kind, want.kind);
         end
         if (rsp_note_count !== want.count) begin
            report_mismatch("note_count", rsp_note_count, want.count);
         end
         if (rsp_status !== want.status) begin
            report_mismatch("status", rsp_status, want.status);
         end
         if (rsp_undispensed !== want.undisp) begin
            report_mismatch("undispensed", rsp_undispensed, want.undisp);
         end
         if (rsp_balance !== want.bal) begin
            report_mismatch("balance", rsp_balance, want.bal);
         end
         if (rsp_last !== want.last) begin
            report_mismatch("last", rsp_last, want.last);
         end
         if (want.last && want.undisp != 0) begin
            shortfalls++;
         end
         if (want.status != STS_OK) begin
            refusals++;
         end
      end
   endtask

   // Requests are predicted before results are checked; a result never belongs to a
   // request taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         restock_all();
         expected_notes.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_request(req_type, req_amount, req_denom_index, req_refill_count);
         end
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
      end
      fail_count <= mismatches;
      pending_count <= expected_notes.size();
      checked_count <= results_seen;
      shortfall_count <= shortfalls;
      refused_count <= refusals;
   end

endmodule

// ===== test/cash_note_dispenser_unit_tb.sv =====
module cash_note_dispenser_unit_tb;
   import cnd_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RANDOM_REQUESTS = 405;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam longint RUN_LIMIT = 12_000_000;
   localparam int unsigned FULL_AMOUNT = 173600;
   localparam int unsigned MAX_REFILL = 12800;

   localparam logic REQ_WITHDRAW = 1'b0;
   localparam logic REQ_REFILL = 1'b1;

   // Denomination indexes, largest note first.
   localparam int unsigned DENOM_500 = 0;
   localparam int unsigned DENOM_150 = 1;
   localparam int unsigned DENOM_50 = 2;
   localparam int unsigned DENOM_20 = 3;
   localparam int unsigned DENOM_10 = 4;
   localparam int unsigned DENOM_5 = 5;
   localparam int unsigned DENOM_2 = 6;
   localparam int unsigned DENOM_1 = 7;

   typedef enum int {
      IDLE_NONE,
      IDLE_LIGHT,
      IDLE_HEAVY
   } idle_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_type = REQ_WITHDRAW;
   logic [AMOUNT_W-1:0] req_amount = '0;
   logic [DENOM_W-1:0]  req_denom_index = '0;
   logic [COUNT_W-1:0]  req_refill_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DENOM_W-1:0]  rsp_note_kind;
   logic [COUNT_W-1:0]  rsp_note_count;
   logic [2:0]          rsp_status;
   logic [AMOUNT_W-1:0] rsp_undispensed;
   logic [AMOUNT_W-1:0] rsp_balance;
   logic                rsp_last;

   int            fail_count;
   int            pending_count;
   int            checked_count;
   int            shortfall_count;
   int            refused_count;
   int            withdrawals_sent;
   int            refills_sent;
   idle_mode_type sender_mode = IDLE_NONE;
   logic          hold_off_request = 1'b0;

   cash_note_dispenser_unit dut (.*);

   cash_note_dispenser_checker u_checker (.*);

   always #(HALF_PERIOD) clock = ~clock;

   // Most gaps are short, a few are long; the mode sets how often they come.
   function automatic int pick_gap(input idle_mode_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == IDLE_NONE || roll < ((mode == IDLE_LIGHT) ? 70 : 30)) begin
         return 0;
      end
      if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   // Offer one request, wait for it to be taken, then idle for a random gap.
   task automatic send_request(input logic kind, input int unsigned amount,
                               input int unsigned idx, input int unsigned count);
      int gap;
      req_type <= kind;
      req_amount <= AMOUNT_W'(amount);
      req_denom_index <= DENOM_W'(idx);
      req_refill_count <= COUNT_W'(count);
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
      if (kind == REQ_REFILL) begin
         refills_sent++;
      end else begin
         withdrawals_sent++;
      end
      gap = pick_gap(sender_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the sender until every expected result has been taken.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_count != 0);
   endtask

   // Random request: refills with small or capacity-sized counts, withdrawals mostly
   // small with some large; the unused fields carry random values as well.
   task automatic send_random_request();
      int unsigned roll;
      int unsigned idx;
      int unsigned count;
      int unsigned amount;
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         idx = $urandom_range(DENOM_500, DENOM_1);
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            count = $urandom_range(0, 50);
         end else if (roll < 80) begin
            count = $urandom_range(0, BASE_STOCK_DEF << idx);
         end else begin
            count = $urandom_range(0, MAX_REFILL);
         end
         send_request(REQ_REFILL, $urandom_range(0, FULL_AMOUNT), idx, count);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            amount = 0;
         end else if (roll < 55) begin
            amount = $urandom_range(1, 2000);
         end else if (roll < 80) begin
            amount = $urandom_range(2001, 30000);
         end else begin
            amount = $urandom_range(0, FULL_AMOUNT);
         end
         send_request(REQ_WITHDRAW, amount, $urandom_range(DENOM_500, DENOM_1),
                      $urandom_range(0, MAX_REFILL));
      end
   endtask

   // Receiver: random stalls in changing modes, and one long hold-off on request.
   initial begin
      int            stall_left;
      int            mode_left;
      idle_mode_type stall_mode;
      logic          held_off;
      stall_left = 0;
      mode_left = 0;
      stall_mode = IDLE_NONE;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !held_off) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               stall_mode = idle_mode_type'($urandom_range(IDLE_NONE, IDLE_HEAVY));
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (stall_left == 0) begin
               stall_left = pick_gap(stall_mode);
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: cancel, refills on a full machine, a withdrawal of the whole stock,
      // requests on an empty machine, a shortfall, and restocking.
      sender_mode <= IDLE_LIGHT;
      send_request(REQ_WITHDRAW, 0, DENOM_500, 0);
      send_request(REQ_REFILL, 0, DENOM_500, 0);
      send_request(REQ_REFILL, 0, DENOM_500, 1);
      send_request(REQ_REFILL, FULL_AMOUNT, DENOM_1, MAX_REFILL);
      send_request(REQ_WITHDRAW, FULL_AMOUNT, DENOM_1, MAX_REFILL);
      send_request(REQ_WITHDRAW, 1, DENOM_500, 0);
      send_request(REQ_WITHDRAW, 0, DENOM_500, 0);
      send_request(REQ_WITHDRAW, FULL_AMOUNT, DENOM_500, 0);
      send_request(REQ_REFILL, 0, DENOM_500, 1);
      send_request(REQ_WITHDRAW, 499, DENOM_500, 0);
      send_request(REQ_WITHDRAW, 501, DENOM_500, 0);
      send_request(REQ_WITHDRAW, 500, DENOM_500, 0);
      send_request(REQ_REFILL, 0, DENOM_1, MAX_REFILL);
      send_request(REQ_REFILL, 0, DENOM_1, 1);
      send_request(REQ_REFILL, 0, DENOM_150, 200);
      send_request(REQ_REFILL, 0, DENOM_2, 6400);
      send_request(REQ_WITHDRAW, 151, DENOM_500, 0);
      send_request(REQ_WITHDRAW, 1, DENOM_500, 0);
      send_request(REQ_REFILL, 0, DENOM_50, 400);
      send_request(REQ_REFILL, 0, DENOM_20, 800);
      send_request(REQ_REFILL, 0, DENOM_10, 1600);
      send_request(REQ_REFILL, 0, DENOM_5, 3200);
      send_request(REQ_REFILL, 0, DENOM_500, 100);
      send_request(REQ_WITHDRAW, 150000, DENOM_500, 0);
      send_request(REQ_WITHDRAW, FULL_AMOUNT, DENOM_500, 0);
      wait_all_results();

      // Random part; the receiver holds off for a long stretch near its start.
      hold_off_request <= 1'b1;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0) begin
            sender_mode <= idle_mode_type'($urandom_range(IDLE_NONE, IDLE_HEAVY));
         end
         if (n == RANDOM_REQUESTS / 2 || $urandom_range(0, 99) == 0) begin
            wait_all_results();
         end
         send_random_request();
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d withdrawals and %0d refills; %0d results were checked.",
               withdrawals_sent, refills_sent, checked_count);
      $display("%0d results carried a refusal status; %0d withdrawals ran short of stock.",
               refused_count, shortfall_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog for a hung block or results that never arrive.
   initial begin
      #(RUN_LIMIT);
      $display("Timeout with %0d results still expected.", pending_count);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
